// ===== sv/i2da_pkg.sv =====
// Package for the binary to decimal ASCII converter.
// Holds the request and result payload types and the character codes.
// No dependencies.
`timescale 1ns / 1ps

package i2da_pkg;

	localparam int VALUE_BITS = 32;
	localparam int CHAR_BITS  = 8;

	localparam logic [CHAR_BITS-1:0] ASCII_ZERO  = 8'h30;
	localparam logic [CHAR_BITS-1:0] ASCII_NINE  = 8'h39;
	localparam logic [CHAR_BITS-1:0] ASCII_MINUS = 8'h2D;

	localparam logic REQ_SIGNED   = 1'b0;
	localparam logic REQ_UNSIGNED = 1'b1;

	typedef struct packed {
		logic                  req_type;
		logic [VALUE_BITS-1:0] value;
	} i2da_req_t;

	typedef struct packed {
		logic [CHAR_BITS-1:0] char_code;
		logic                 last;
	} i2da_res_t;

endpackage

// ===== sv/i2da_dabble.sv =====
// Iterative binary to BCD converter: one shift/add-3 step per cycle.
// After load, it pulses done once bcd holds the result.
// No package dependencies.
`timescale 1ns / 1ps

module i2da_dabble #(
	parameter int WIDTH = 32,
	parameter int NDIG  = 11
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  logic [WIDTH-1:0]  mag,
	output logic              done,
	output logic [NDIG*4-1:0] bcd
);

	localparam int CW = $clog2(WIDTH + 1);
	localparam int NB = NDIG * 4;

	logic [WIDTH-1:0] bin_q;
	logic [NB-1:0]    bcd_q;
	logic [NB-1:0]    adj;
	logic [CW-1:0]    cnt_q;
	logic             run_q;
	logic             done_q;

	// add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_q[i*4 +: 4] >= 4'd5) begin
				adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
			end else begin
				adj[i*4 +: 4] = bcd_q[i*4 +: 4];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (load) begin
				run_q <= 1'b1;
				cnt_q <= CW'(WIDTH);
			end else if (run_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bin_q <= mag;
			bcd_q <= '0;
		end else if (run_q) begin
			bcd_q <= {adj[NB-2:0], bin_q[WIDTH-1]};
			bin_q <= {bin_q[WIDTH-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule

// ===== sv/int_to_decimal_ascii.sv =====
// Top level of the binary to decimal ASCII converter.
// Depends on i2da_pkg and i2da_dabble.
//
// Usage: drive request and raise start; the request is taken at a rising edge
// with start high and busy low. req_type 0 reads value as two's complement,
// 1 as unsigned; value is taken at VALUE_WIDTH bits (zero-extended above the
// 32-bit field). The characters come out on result, most significant first,
// one per cycle, each marked by strobe for exactly one cycle; result.last is
// set on the final one. A negative signed value starts with '-'; zero gives '0'.
// The magnitude runs through a shift/add-3 loop of VALUE_WIDTH steps, then one
// character leaves per cycle. busy stays high from the taken request until the
// final character is issued, so the next request waits for it; a number has up
// to 11 characters at 32 bits.
// The receiver cannot stall: every strobe is taken. Reset clears the sequencer
// and the strobe; a request in flight is dropped.
`timescale 1ns / 1ps

module int_to_decimal_ascii
	import i2da_pkg::*;
#(
	parameter int VALUE_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  i2da_req_t request,
	output logic      strobe,
	output i2da_res_t result
);

	localparam int NDIG = (VALUE_WIDTH * 1233) / 4096 + 2;
	localparam int PW   = $clog2(NDIG);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CONV  = 2'd1;
	localparam logic [1:0] ST_SIGN  = 2'd2;
	localparam logic [1:0] ST_DIGIT = 2'd3;

	logic [1:0]                    state_q;
	logic                          neg_q;
	logic [PW-1:0]                 ptr_q;
	logic                          strobe_q;
	i2da_res_t                     result_q;

	logic                          accept;
	logic [VALUE_WIDTH+VALUE_BITS-1:0] value_wide;
	logic [VALUE_WIDTH-1:0]        value_ext;
	logic                          neg;
	logic [VALUE_WIDTH-1:0]        mag;
	logic                          conv_done;
	logic [NDIG*4-1:0]             bcd;
	logic [PW-1:0]                 top_idx;
	logic [3:0]                    digit;

	assign accept     = start && !busy;
	assign busy       = (state_q != ST_IDLE);
	assign value_wide = {{VALUE_WIDTH{1'b0}}, request.value};
	assign value_ext  = value_wide[VALUE_WIDTH-1:0];
	assign neg        = (request.req_type == REQ_SIGNED) && value_ext[VALUE_WIDTH-1];
	// two's complement negation; the most negative value maps onto itself
	assign mag        = neg ? (~value_ext + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : value_ext;

	i2da_dabble #(
		.WIDTH (VALUE_WIDTH),
		.NDIG  (NDIG)
	) u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (accept),
		.mag    (mag),
		.done   (conv_done),
		.bcd    (bcd)
	);

	// highest nonzero digit; zero keeps a single digit
	always_comb begin
		top_idx = '0;
		for (int i = 0; i < NDIG; i++) begin
			if (bcd[i*4 +: 4] != 4'd0) begin
				top_idx = PW'(i);
			end
		end
	end

	assign digit = bcd[{ptr_q, 2'b00} +: 4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			strobe_q <= 1'b0;
			neg_q    <= 1'b0;
			ptr_q    <= '0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						neg_q   <= neg;
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (conv_done) begin
						ptr_q   <= top_idx;
						state_q <= neg_q ? ST_SIGN : ST_DIGIT;
					end
				end
				ST_SIGN: begin
					strobe_q <= 1'b1;
					state_q  <= ST_DIGIT;
				end
				ST_DIGIT: begin
					strobe_q <= 1'b1;
					if (ptr_q == '0) begin
						state_q <= ST_IDLE;
					end else begin
						ptr_q <= ptr_q - PW'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SIGN) begin
			result_q.char_code <= ASCII_MINUS;
			result_q.last      <= 1'b0;
		end else if (state_q == ST_DIGIT) begin
			result_q.char_code <= ASCII_ZERO + {4'd0, digit};
			result_q.last      <= (ptr_q == '0);
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

endmodule

// ===== sv/i2da_check.sv =====
// Port-level checker for int_to_decimal_ascii, bound to the top level.
// Depends on i2da_pkg.
`timescale 1ns / 1ps

module i2da_check
	import i2da_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input logic      strobe,
	input i2da_res_t result
);

	// characters of one number leave back to back
	a_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |=> strobe)
		else $error("character stream broke before last");

	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after request");

	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (result.char_code == ASCII_MINUS) ||
			((result.char_code >= ASCII_ZERO) && (result.char_code <= ASCII_NINE)))
		else $error("character outside '-' and digits");

	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (result.char_code == ASCII_MINUS) |-> !result.last)
		else $error("sign marked as last character");

endmodule

bind int_to_decimal_ascii i2da_check u_i2da_check (.*);
